// File: src/fis_pkg.sv
// ----------------------------------------------------------------------------
// fis_pkg: shared types and constants of the frame index search block
// Field widths, table geometry, opcodes, status codes and the command and
// status bundles between the controller and the datapath.
// ----------------------------------------------------------------------------
package fis_pkg;

	// Table geometry.
	localparam int DEPTH = 4096;
	localparam int AW    = $clog2(DEPTH);
	localparam int CW    = AW + 1;
	localparam int SW    = AW + 2;

	// Stream widths.
	localparam int IN_TDATA_W  = 184;
	localparam int OUT_TDATA_W = 232;

	// Operations carried on the input tuser.
	localparam logic [1:0] OP_APPEND = 2'd0;
	localparam logic [1:0] OP_SEARCH = 2'd1;
	localparam logic [1:0] OP_CLEAR  = 2'd2;
	localparam logic [1:0] OP_UNUSED = 2'd3;

	// Search modes.
	localparam logic [1:0] MODE_TC  = 2'd0;
	localparam logic [1:0] MODE_PTS = 2'd1;
	localparam logic [1:0] MODE_DTS = 2'd2;
	localparam logic [1:0] MODE_BAD = 2'd3;

	// Result status codes.
	localparam logic [2:0] ST_DONE    = 3'd0;
	localparam logic [2:0] ST_FOUND   = 3'd1;
	localparam logic [2:0] ST_MISS    = 3'd2;
	localparam logic [2:0] ST_INVALID = 3'd3;
	localparam logic [2:0] ST_FULL    = 3'd4;

	// Picture kinds.
	localparam logic [7:0] KIND_I = 8'd1;
	localparam logic [7:0] KIND_B = 8'd3;

	// Timecode packing weights.
	localparam logic [32:0] TC_H_MUL = 33'd1000000;
	localparam logic [32:0] TC_M_MUL = 33'd10000;
	localparam logic [32:0] TC_S_MUL = 33'd100;

	// Datapath commands.
	localparam int CMD_W = 5;
	localparam logic [CMD_W-1:0] CMD_NONE    = 5'd0;
	localparam logic [CMD_W-1:0] CMD_LOAD    = 5'd1;
	localparam logic [CMD_W-1:0] CMD_BRD     = 5'd2;
	localparam logic [CMD_W-1:0] CMD_BCMP    = 5'd3;
	localparam logic [CMD_W-1:0] CMD_BHIT    = 5'd4;
	localparam logic [CMD_W-1:0] CMD_DMID    = 5'd5;
	localparam logic [CMD_W-1:0] CMD_WRD     = 5'd6;
	localparam logic [CMD_W-1:0] CMD_WSTEP   = 5'd7;
	localparam logic [CMD_W-1:0] CMD_DSET    = 5'd8;
	localparam logic [CMD_W-1:0] CMD_RRD     = 5'd9;
	localparam logic [CMD_W-1:0] CMD_RNEXT   = 5'd10;
	localparam logic [CMD_W-1:0] CMD_RNARROW = 5'd11;
	localparam logic [CMD_W-1:0] CMD_REND    = 5'd12;
	localparam logic [CMD_W-1:0] CMD_RHIT    = 5'd13;
	localparam logic [CMD_W-1:0] CMD_FRD     = 5'd14;
	localparam logic [CMD_W-1:0] CMD_FLATCH  = 5'd15;
	localparam logic [CMD_W-1:0] CMD_K1RD    = 5'd16;
	localparam logic [CMD_W-1:0] CMD_K1NEXT  = 5'd17;
	localparam logic [CMD_W-1:0] CMD_K2INIT  = 5'd18;
	localparam logic [CMD_W-1:0] CMD_K2RD    = 5'd19;
	localparam logic [CMD_W-1:0] CMD_K2DEC   = 5'd20;
	localparam logic [CMD_W-1:0] CMD_KLATCH  = 5'd21;
	localparam logic [CMD_W-1:0] CMD_PUBLISH = 5'd22;

	// One table entry as stored in the memory.
	typedef struct packed {
		logic [4:0]  tc_h;
		logic [5:0]  tc_m;
		logic [5:0]  tc_s;
		logic [5:0]  tc_f;
		logic [7:0]  kind;
		logic [47:0] offset;
		logic [32:0] dts;
		logic [32:0] pts;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	typedef struct packed {
		logic [CMD_W-1:0] code;
	} cmd_t;

	typedef struct packed {
		logic [1:0] op;
		logic [1:0] mode;
		logic       count_zero;
		logic       lo_gt_hi;
		logic       iter_gt_n;
		logic       kf_pos;
		logic       kf_eq_prev;
		logic       j_lt_n;
		logic       i_lt_n;
		logic       i_zero;
		logic       b_eq;
		logic       d_eq;
		logic       kind_b;
		logic       kind_i;
		logic       dts_lt;
	} sts_t;

endpackage

// File: src/frame_index_search.sv
// ----------------------------------------------------------------------------
// frame_index_search: video frame index table with search
// Top level joining the controller and the datapath.
// ----------------------------------------------------------------------------
// Usage:
// Input items arrive on the s_ stream; s_tuser carries the operation (append,
// search, clear). Every item yields exactly one result item on the m_ stream,
// with the status code on m_tuser and the found entry and its key frame on
// m_tdata. One item is worked on at a time; s_tready is high only while the
// block waits for an item.
// Append, clear and invalid items pass from acceptance through the dispatch and
// finish steps to the output register; the next item is accepted once the
// controller is back in idle. A pts or timecode search reads the table once
// per binary search probe, up to 13 probes over a full table, then reads the
// found entry again and reads each entry that the key frame scan visits. A dts
// search reads each entry visited in each backward walk and B-frame run, and
// every probe sets a clamped midpoint before its walk. All reads share the
// one read port of the table memory, whose read data is registered.
// Reset empties the table at once (the entry count is cleared; no memory
// sweep) and drops any pending result.
// When the receiver stalls, the finished result holds in the output register;
// the next item may be accepted meanwhile, and its result waits in the last
// step until the register frees up.
// ----------------------------------------------------------------------------
module frame_index_search (
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               s_tvalid,
	output logic                               s_tready,
	// pts_value, dts_value, stream_offset, picture_kind, tc_hours, tc_minutes,
	// tc_seconds, tc_frames, search_key, search_mode, zero fill
	input  logic [fis_pkg::IN_TDATA_W-1:0]     s_tdata,
	// operation
	input  logic [1:0]                         s_tuser,
	output logic                               m_tvalid,
	input  logic                               m_tready,
	// position, found_pts, found_dts, found_offset, found_kind, key_valid,
	// key_position, key_offset, key_dts, zero fill
	output logic [fis_pkg::OUT_TDATA_W-1:0]    m_tdata,
	// status
	output logic [2:0]                         m_tuser
);
	import fis_pkg::*;

	cmd_t cmd;
	sts_t sts;

	fis_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.s_tvalid (s_tvalid),
		.s_tready (s_tready),
		.m_tvalid (m_tvalid),
		.m_tready (m_tready),
		.sts      (sts),
		.cmd      (cmd)
	);

	fis_dpath u_dpath (
		.clk     (clk),
		.arst_n  (arst_n),
		.cmd     (cmd),
		.s_tdata (s_tdata),
		.s_tuser (s_tuser),
		.sts     (sts),
		.m_tdata (m_tdata),
		.m_tuser (m_tuser)
	);

endmodule

// File: src/fis_ram.sv
// ----------------------------------------------------------------------------
// fis_ram: generic single-write, single-read RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module fis_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write and registered read.
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

// File: src/fis_dpath.sv
// ----------------------------------------------------------------------------
// fis_dpath: datapath of the frame index search
// Entry count, table memory, search bounds and cursors, result assembly and
// the output register. Acts on one command from the controller per cycle.
// ----------------------------------------------------------------------------
module fis_dpath (
	input  logic                               clk,
	input  logic                               arst_n,
	input  fis_pkg::cmd_t                      cmd,
	input  logic [fis_pkg::IN_TDATA_W-1:0]     s_tdata,
	input  logic [1:0]                         s_tuser,
	output fis_pkg::sts_t                      sts,
	output logic [fis_pkg::OUT_TDATA_W-1:0]    m_tdata,
	output logic [2:0]                         m_tuser
);
	import fis_pkg::*;

	logic [CW-1:0]        count_q;
	logic [1:0]           op_q;
	logic [1:0]           mode_q;
	logic [32:0]          key_q;
	logic signed [SW-1:0] lo_q, hi_q, iter_q, kf_q, prev_q, j_q, i_q;
	logic [AW-1:0]        mid_q, pos_q;
	logic [2:0]           res_status_q;
	logic [AW-1:0]        res_pos_q;
	logic [32:0]          fnd_pts_q, fnd_dts_q;
	logic [47:0]          fnd_off_q;
	logic [7:0]           fnd_kind_q;
	logic                 key_valid_q;
	logic [AW-1:0]        key_pos_q;
	logic [47:0]          key_off_q;
	logic [32:0]          key_dts_q;
	logic [OUT_TDATA_W-1:0] out_tdata_q;
	logic [2:0]           out_tuser_q;

	entry_t               in_entry, rd;
	logic                 full_c, we_c;
	logic [AW-1:0]        raddr_c;
	logic signed [SW-1:0] n_s, n_m1, half_c, dmid_c, mid_s;
	logic signed [SW:0]   sum_c;
	logic [32:0]          tc_c, probe_c;

	// Unpack the appended entry from the input item.
	assign in_entry.pts    = s_tdata[32:0];
	assign in_entry.dts    = s_tdata[65:33];
	assign in_entry.offset = s_tdata[113:66];
	assign in_entry.kind   = s_tdata[121:114];
	assign in_entry.tc_h   = s_tdata[126:122];
	assign in_entry.tc_m   = s_tdata[132:127];
	assign in_entry.tc_s   = s_tdata[138:133];
	assign in_entry.tc_f   = s_tdata[144:139];

	// Bounds arithmetic.
	assign full_c = (count_q == CW'(DEPTH));
	assign n_s    = signed'({1'b0, count_q});
	assign n_m1   = n_s - SW'(1);
	assign sum_c  = {lo_q[SW-1], lo_q} + {hi_q[SW-1], hi_q};
	assign half_c = sum_c[SW:1];
	assign mid_s  = signed'({2'b00, mid_q});

	// Dts probe midpoint, clamped into the filled part of the table.
	always_comb begin
		if (half_c < 0) begin
			dmid_c = '0;
		end else if (half_c > n_m1) begin
			dmid_c = n_m1;
		end else begin
			dmid_c = half_c;
		end
	end

	// Memory read address for the current command.
	always_comb begin
		case (cmd.code)
			CMD_BRD:              raddr_c = half_c[AW-1:0];
			CMD_WRD:              raddr_c = kf_q[AW-1:0];
			CMD_RRD:              raddr_c = j_q[AW-1:0];
			CMD_FRD:              raddr_c = pos_q;
			CMD_K1RD, CMD_K2RD:   raddr_c = i_q[AW-1:0];
			default:              raddr_c = '0;
		endcase
	end

	assign we_c = (cmd.code == CMD_LOAD) && (s_tuser == OP_APPEND) && !full_c;

	fis_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (DEPTH)
	) u_table (
		.clk   (clk),
		.we    (we_c),
		.waddr (count_q[AW-1:0]),
		.wdata (in_entry),
		.raddr (raddr_c),
		.rdata (rd)
	);

	// Packed timecode of the entry just read.
	assign tc_c = 33'(rd.tc_h) * TC_H_MUL + 33'(rd.tc_m) * TC_M_MUL
		+ 33'(rd.tc_s) * TC_S_MUL + 33'(rd.tc_f);
	assign probe_c = (mode_q == MODE_TC) ? tc_c : rd.pts;

	// Status toward the controller.
	assign sts.op         = op_q;
	assign sts.mode       = mode_q;
	assign sts.count_zero = (count_q == '0);
	assign sts.lo_gt_hi   = (lo_q > hi_q);
	assign sts.iter_gt_n  = (iter_q > n_s);
	assign sts.kf_pos     = (kf_q > 0);
	assign sts.kf_eq_prev = (kf_q == prev_q);
	assign sts.j_lt_n     = (j_q < n_s);
	assign sts.i_lt_n     = (i_q < n_s);
	assign sts.i_zero     = (i_q == 0);
	assign sts.b_eq       = (probe_c == key_q);
	assign sts.d_eq       = (rd.dts == key_q);
	assign sts.kind_b     = (rd.kind == KIND_B);
	assign sts.kind_i     = (rd.kind == KIND_I);
	assign sts.dts_lt     = (rd.dts < fnd_dts_q);

	// Entry count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (cmd.code == CMD_LOAD) begin
			if (s_tuser == OP_APPEND && !full_c) begin
				count_q <= count_q + CW'(1);
			end else if (s_tuser == OP_CLEAR) begin
				count_q <= '0;
			end
		end
	end

	// Search registers and result assembly.
	always_ff @(posedge clk) begin
		case (cmd.code)
			CMD_LOAD: begin
				op_q         <= s_tuser;
				mode_q       <= s_tdata[179:178];
				key_q        <= s_tdata[177:145];
				lo_q         <= '0;
				hi_q         <= n_m1;
				iter_q       <= '0;
				// All ones but the lowest bit: minus two, no key frame yet.
				prev_q       <= ~SW'(1);
				// An append that fits reports the row it wrote; everything else row zero.
				res_pos_q    <= (s_tuser == OP_APPEND && !full_c) ? count_q[AW-1:0] : '0;
				fnd_pts_q    <= '0;
				fnd_dts_q    <= '0;
				fnd_off_q    <= '0;
				fnd_kind_q   <= '0;
				key_valid_q  <= 1'b0;
				key_pos_q    <= '0;
				key_off_q    <= '0;
				key_dts_q    <= '0;
				case (s_tuser)
					OP_APPEND: res_status_q <= full_c ? ST_FULL : ST_DONE;
					OP_SEARCH: res_status_q <= (s_tdata[179:178] == MODE_BAD) ?
						ST_INVALID : ST_MISS;
					OP_CLEAR:  res_status_q <= ST_DONE;
					default:   res_status_q <= ST_INVALID;
				endcase
			end
			CMD_BRD:  mid_q <= half_c[AW-1:0];
			CMD_BCMP: begin
				if (probe_c > key_q) begin
					hi_q <= mid_s - SW'(1);
				end else begin
					lo_q <= mid_s + SW'(1);
				end
			end
			CMD_BHIT:  pos_q <= mid_q;
			CMD_DMID:  kf_q <= dmid_c;
			CMD_WSTEP: kf_q <= kf_q - SW'(1);
			CMD_DSET: begin
				prev_q <= kf_q;
				j_q    <= kf_q + SW'(1);
			end
			CMD_RNEXT: j_q <= j_q + SW'(1);
			CMD_RNARROW: begin
				if (key_q > rd.dts) begin
					lo_q <= kf_q + SW'(1);
				end else begin
					hi_q <= kf_q - SW'(1);
				end
				iter_q <= iter_q + SW'(1);
			end
			CMD_REND: begin
				hi_q   <= kf_q - SW'(1);
				iter_q <= iter_q + SW'(1);
			end
			CMD_RHIT: pos_q <= j_q[AW-1:0];
			CMD_FLATCH: begin
				res_status_q <= ST_FOUND;
				res_pos_q    <= pos_q;
				fnd_pts_q    <= rd.pts;
				fnd_dts_q    <= rd.dts;
				fnd_off_q    <= rd.offset;
				fnd_kind_q   <= rd.kind;
				i_q          <= signed'({2'b00, pos_q});
			end
			CMD_K1NEXT: i_q <= i_q + SW'(1);
			CMD_K2INIT: i_q <= signed'({2'b00, pos_q});
			CMD_K2DEC:  i_q <= i_q - SW'(1);
			CMD_KLATCH: begin
				key_valid_q <= 1'b1;
				key_pos_q   <= i_q[AW-1:0];
				key_off_q   <= rd.offset;
				key_dts_q   <= rd.dts;
			end
			CMD_PUBLISH: begin
				out_tdata_q <= {4'b0000, key_dts_q, key_off_q, 12'(key_pos_q), key_valid_q,
					fnd_kind_q, fnd_off_q, fnd_dts_q, fnd_pts_q, 12'(res_pos_q)};
				out_tuser_q <= res_status_q;
			end
			default: begin
			end
		endcase
	end

	assign m_tdata = out_tdata_q;
	assign m_tuser = out_tuser_q;

	// The table never holds more entries than it has rows.
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CW'(DEPTH))
		else $error("entry count beyond table depth");

endmodule

// File: src/fis_ctrl.sv
// ----------------------------------------------------------------------------
// fis_ctrl: controller of the frame index search
// Sequences append, clear, binary, dts and key frame searches, and hands the
// finished result to the output register.
// ----------------------------------------------------------------------------
module fis_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          s_tvalid,
	output logic          s_tready,
	output logic          m_tvalid,
	input  logic          m_tready,
	input  fis_pkg::sts_t sts,
	output fis_pkg::cmd_t cmd
);
	import fis_pkg::*;

	localparam logic [4:0] S_IDLE   = 5'd0;
	localparam logic [4:0] S_DISP   = 5'd1;
	localparam logic [4:0] S_BPROBE = 5'd2;
	localparam logic [4:0] S_BCMP   = 5'd3;
	localparam logic [4:0] S_DPROBE = 5'd4;
	localparam logic [4:0] S_WALK   = 5'd5;
	localparam logic [4:0] S_WCHK   = 5'd6;
	localparam logic [4:0] S_DSET   = 5'd7;
	localparam logic [4:0] S_RUN    = 5'd8;
	localparam logic [4:0] S_RCHK   = 5'd9;
	localparam logic [4:0] S_FRD    = 5'd10;
	localparam logic [4:0] S_FCHK   = 5'd11;
	localparam logic [4:0] S_K1     = 5'd12;
	localparam logic [4:0] S_K1C    = 5'd13;
	localparam logic [4:0] S_K2     = 5'd14;
	localparam logic [4:0] S_K2C    = 5'd15;
	localparam logic [4:0] S_FINISH = 5'd16;

	logic [4:0] state_q, state_d;
	logic       out_valid_q;
	logic       publish_c;

	assign s_tready  = (state_q == S_IDLE);
	assign m_tvalid  = out_valid_q;
	assign publish_c = (cmd.code == CMD_PUBLISH);

	// Next state and command.
	always_comb begin
		state_d  = state_q;
		cmd.code = CMD_NONE;
		case (state_q)
			S_IDLE: begin
				if (s_tvalid) begin
					cmd.code = CMD_LOAD;
					state_d  = S_DISP;
				end
			end
			S_DISP: begin
				if (sts.op == OP_SEARCH && sts.mode != MODE_BAD && !sts.count_zero) begin
					state_d = (sts.mode == MODE_DTS) ? S_DPROBE : S_BPROBE;
				end else begin
					state_d = S_FINISH;
				end
			end
			S_BPROBE: begin
				if (sts.lo_gt_hi) begin
					state_d = S_FINISH;
				end else begin
					cmd.code = CMD_BRD;
					state_d  = S_BCMP;
				end
			end
			S_BCMP: begin
				cmd.code = sts.b_eq ? CMD_BHIT : CMD_BCMP;
				state_d  = sts.b_eq ? S_FRD : S_BPROBE;
			end
			S_DPROBE: begin
				if (sts.iter_gt_n) begin
					state_d = S_FINISH;
				end else begin
					cmd.code = CMD_DMID;
					state_d  = S_WALK;
				end
			end
			S_WALK: begin
				if (sts.kf_pos) begin
					cmd.code = CMD_WRD;
					state_d  = S_WCHK;
				end else begin
					state_d = S_DSET;
				end
			end
			S_WCHK: begin
				if (sts.kind_b) begin
					cmd.code = CMD_WSTEP;
					state_d  = S_WALK;
				end else begin
					state_d = S_DSET;
				end
			end
			S_DSET: begin
				if (sts.kf_eq_prev) begin
					state_d = S_FINISH;
				end else begin
					cmd.code = CMD_DSET;
					state_d  = S_RUN;
				end
			end
			S_RUN: begin
				if (sts.j_lt_n) begin
					cmd.code = CMD_RRD;
					state_d  = S_RCHK;
				end else begin
					cmd.code = CMD_REND;
					state_d  = S_DPROBE;
				end
			end
			S_RCHK: begin
				if (sts.d_eq) begin
					cmd.code = CMD_RHIT;
					state_d  = S_FRD;
				end else if (sts.kind_b) begin
					cmd.code = CMD_RNEXT;
					state_d  = S_RUN;
				end else begin
					cmd.code = CMD_RNARROW;
					state_d  = S_DPROBE;
				end
			end
			S_FRD: begin
				cmd.code = CMD_FRD;
				state_d  = S_FCHK;
			end
			S_FCHK: begin
				cmd.code = CMD_FLATCH;
				state_d  = sts.kind_i ? S_FINISH : S_K1;
			end
			S_K1: begin
				if (sts.i_lt_n) begin
					cmd.code = CMD_K1RD;
					state_d  = S_K1C;
				end else begin
					cmd.code = CMD_K2INIT;
					state_d  = S_K2;
				end
			end
			S_K1C: begin
				if (sts.kind_i && sts.dts_lt) begin
					cmd.code = CMD_KLATCH;
					state_d  = S_FINISH;
				end else begin
					cmd.code = CMD_K1NEXT;
					state_d  = S_K1;
				end
			end
			S_K2: begin
				cmd.code = CMD_K2RD;
				state_d  = S_K2C;
			end
			S_K2C: begin
				if (sts.kind_i) begin
					cmd.code = CMD_KLATCH;
					state_d  = S_FINISH;
				end else if (sts.i_zero) begin
					state_d = S_FINISH;
				end else begin
					cmd.code = CMD_K2DEC;
					state_d  = S_K2;
				end
			end
			S_FINISH: begin
				if (!out_valid_q || m_tready) begin
					cmd.code = CMD_PUBLISH;
					state_d  = S_IDLE;
				end
			end
			default: state_d = S_IDLE;
		endcase
	end

	// State and output valid registers.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (publish_c) begin
				out_valid_q <= 1'b1;
			end else if (m_tready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// An accepted item keeps the input closed until its result is handed over.
	a_busy_after_accept: assert property (@(posedge clk) disable iff (!arst_n)
		s_tvalid && s_tready |=> !s_tready)
		else $error("input accepted twice in a row");

	// A result never overwrites one that is still waiting.
	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		publish_c |-> (!out_valid_q || m_tready))
		else $error("result overwrites a pending one");

	// Publishing always presents a result in the next cycle.
	a_publish_valid: assert property (@(posedge clk) disable iff (!arst_n)
		publish_c |=> m_tvalid)
		else $error("published result not shown");

	// The input opens only after a result has been handed over.
	a_ready_after_publish: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(s_tready) |-> $past(publish_c))
		else $error("input reopened without a result");

endmodule
